>>> rtl/hct_pkg.sv
// ============================================================================
// hct_pkg
// Shared constants, payload types and fixed-point helpers for the HSV tint
// pipeline.
// ============================================================================
package hct_pkg;

    localparam int FRAC_BITS   = 12;
    localparam int Q_W         = FRAC_BITS + 1;
    localparam int ONE         = 1 << FRAC_BITS;
    localparam int HALF        = 1 << (FRAC_BITS - 1);
    localparam int TURN        = 6 * ONE;
    localparam int H_W         = $clog2(TURN);
    localparam int IDX_W       = 17;
    localparam int OUT_IDX_W   = 16;
    localparam int ADJ_W       = 16;
    localparam int CNT_W       = 17;
    localparam int MAX_RECORDS = 65536;
    localparam int LIM_W       = $clog2(MAX_RECORDS + 1);
    localparam int CMP_W       = (LIM_W > CNT_W) ? LIM_W : CNT_W;
    localparam int DVD_W       = 2 * FRAC_BITS + 1;
    localparam int PROD_W      = 32;
    localparam int MUL_W       = 2 * Q_W;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;

    localparam int FRONT_STAGES = 2;
    localparam int DIV_STAGES   = Q_W;
    localparam int ADJ_STAGES   = 2;
    localparam int RGB_STAGES   = 4;
    localparam int N_STAGES     = FRONT_STAGES + DIV_STAGES + ADJ_STAGES + RGB_STAGES;

    localparam logic [Q_W-1:0] ONE_Q  = Q_W'(ONE);
    localparam logic [0:0]     REG_RECORD_COUNT = 1'b0;

    typedef enum logic [2:0] {
        SECT_RED     = 3'd0,
        SECT_YELLOW  = 3'd1,
        SECT_GREEN   = 3'd2,
        SECT_CYAN    = 3'd3,
        SECT_BLUE    = 3'd4,
        SECT_MAGENTA = 3'd5
    } sector_t;

    // Fields that ride along to the output stage; alpha is scaled by record_alpha in the front end
    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic                 skipped;
        logic                 enable;
        logic [Q_W-1:0]       red;
        logic [Q_W-1:0]       green;
        logic [Q_W-1:0]       blue;
        logic [Q_W-1:0]       alpha;
    } pass_t;

    // Sideband alongside the divider lanes
    typedef struct packed {
        pass_t                    pass;
        logic signed [ADJ_W-1:0]  sat_adj;
        logic                     sat_add;
        logic signed [ADJ_W-1:0]  val_adj;
        logic                     val_add;
        logic [FRAC_BITS-1:0]     hue_sh;
        logic [H_W-1:0]           base;
        logic                     neg;
        logic [Q_W-1:0]           value;
    } side_t;

    typedef struct packed {
        pass_t          pass;
        logic [H_W-1:0] hue;
        logic [Q_W-1:0] sat;
        logic [Q_W-1:0] value;
    } hsv_t;

    typedef struct packed {
        logic [OUT_IDX_W-1:0] index;
        logic                 skipped;
        logic [Q_W-1:0]       red;
        logic [Q_W-1:0]       green;
        logic [Q_W-1:0]       blue;
        logic [Q_W-1:0]       alpha;
    } result_t;

    function automatic logic [Q_W-1:0] clamp_unit(input logic [Q_W-1:0] x);
        return (x > ONE_Q) ? ONE_Q : x;
    endfunction

    function automatic logic [Q_W-1:0] sat_unit(input logic signed [PROD_W-1:0] x);
        logic [Q_W-1:0] r;
        if (x < 0)
            r = '0;
        else if (x > ONE)
            r = ONE_Q;
        else
            r = x[Q_W-1:0];
        return r;
    endfunction

    // rounded Q product, zero when the raw product is not positive
    function automatic logic signed [PROD_W-1:0] qmul_pos(
        input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] r;
        if (p <= 0)
            r = '0;
        else
            r = (p + PROD_W'(HALF)) >>> FRAC_BITS;
        return r;
    endfunction

    function automatic logic [Q_W-1:0] round_q(input logic [MUL_W-1:0] p);
        logic [MUL_W-1:0] t;
        t = p + MUL_W'(HALF);
        return t[FRAC_BITS +: Q_W];
    endfunction

endpackage

>>> rtl/hct_front.sv
// ============================================================================
// hct_front
// Input capture, range check, max/min search and divider operand setup.
// ============================================================================
module hct_front (
    input  logic                                    clk,
    input  logic [1:0]                              en,
    input  logic [hct_pkg::CNT_W-1:0]               record_count,
    input  logic signed [hct_pkg::IDX_W-1:0]        record_index,
    input  logic [hct_pkg::Q_W-1:0]                 channel_red,
    input  logic [hct_pkg::Q_W-1:0]                 channel_green,
    input  logic [hct_pkg::Q_W-1:0]                 channel_blue,
    input  logic [hct_pkg::Q_W-1:0]                 channel_alpha,
    input  logic                                    adjust_enable,
    input  logic signed [hct_pkg::ADJ_W-1:0]        hue_shift,
    input  logic signed [hct_pkg::ADJ_W-1:0]        sat_adjust,
    input  logic                                    sat_additive,
    input  logic signed [hct_pkg::ADJ_W-1:0]        val_adjust,
    input  logic                                    val_additive,
    input  logic [hct_pkg::Q_W-1:0]                 record_alpha,
    output hct_pkg::side_t                          side,
    output logic [hct_pkg::DVD_W-1:0]               dvd_hue,
    output logic [hct_pkg::Q_W-1:0]                 den_hue,
    output logic [hct_pkg::DVD_W-1:0]               dvd_sat,
    output logic [hct_pkg::Q_W-1:0]                 den_sat
);

    typedef struct packed {
        hct_pkg::pass_t                          pass;
        logic [hct_pkg::Q_W-1:0]                 record_alpha;
        logic signed [hct_pkg::ADJ_W-1:0]        sat_adj;
        logic                                    sat_add;
        logic signed [hct_pkg::ADJ_W-1:0]        val_adj;
        logic                                    val_add;
        logic [hct_pkg::FRAC_BITS-1:0]           hue_sh;
    } capture_t;

    capture_t                        cap_next;
    capture_t                        cap_reg;
    logic [hct_pkg::CMP_W-1:0]       limit;
    logic [hct_pkg::CMP_W-1:0]       rc_ext;

    hct_pkg::side_t                  side_next;
    hct_pkg::side_t                  side_reg;
    logic [hct_pkg::DVD_W-1:0]       dvd_hue_next, dvd_hue_reg;
    logic [hct_pkg::DVD_W-1:0]       dvd_sat_next, dvd_sat_reg;
    logic [hct_pkg::Q_W-1:0]         den_hue_next, den_hue_reg;
    logic [hct_pkg::Q_W-1:0]         den_sat_next, den_sat_reg;
    logic [hct_pkg::Q_W-1:0]         mx, mn, delta, abs_diff;
    logic signed [hct_pkg::Q_W:0]    diff;
    logic [hct_pkg::H_W-1:0]         base;
    logic [hct_pkg::MUL_W-1:0]       alpha_prod;

    // Stage 0: clamp colors, check the index against the record bound
    always_comb
    begin
        rc_ext = hct_pkg::CMP_W'(record_count);
        limit  = (rc_ext > hct_pkg::CMP_W'(hct_pkg::MAX_RECORDS))
               ? hct_pkg::CMP_W'(hct_pkg::MAX_RECORDS) : rc_ext;
        cap_next.pass.index   = record_index[hct_pkg::OUT_IDX_W-1:0];
        cap_next.pass.skipped = record_index[hct_pkg::IDX_W-1]
            || (hct_pkg::CMP_W'(record_index[hct_pkg::OUT_IDX_W-1:0]) >= limit);
        cap_next.pass.enable  = adjust_enable;
        cap_next.pass.red     = hct_pkg::clamp_unit(channel_red);
        cap_next.pass.green   = hct_pkg::clamp_unit(channel_green);
        cap_next.pass.blue    = hct_pkg::clamp_unit(channel_blue);
        cap_next.pass.alpha   = hct_pkg::clamp_unit(channel_alpha);
        cap_next.record_alpha = hct_pkg::clamp_unit(record_alpha);
        cap_next.sat_adj      = sat_adjust;
        cap_next.sat_add      = sat_additive;
        cap_next.val_adj      = val_adjust;
        cap_next.val_add      = val_additive;
        cap_next.hue_sh       = hue_shift[hct_pkg::FRAC_BITS-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            cap_reg <= cap_next;
    end

    // Stage 1: max/min, hue sector, divider operands, alpha product
    always_comb
    begin
        mx = cap_reg.pass.red;
        mn = cap_reg.pass.red;
        if (cap_reg.pass.green > mx) mx = cap_reg.pass.green;
        if (cap_reg.pass.blue  > mx) mx = cap_reg.pass.blue;
        if (cap_reg.pass.green < mn) mn = cap_reg.pass.green;
        if (cap_reg.pass.blue  < mn) mn = cap_reg.pass.blue;
        delta = mx - mn;

        if (cap_reg.pass.red == mx)
        begin
            diff = $signed({1'b0, cap_reg.pass.green}) - $signed({1'b0, cap_reg.pass.blue});
            base = '0;
        end
        else if (cap_reg.pass.green == mx)
        begin
            diff = $signed({1'b0, cap_reg.pass.blue}) - $signed({1'b0, cap_reg.pass.red});
            base = hct_pkg::H_W'(2 * hct_pkg::ONE);
        end
        else
        begin
            diff = $signed({1'b0, cap_reg.pass.red}) - $signed({1'b0, cap_reg.pass.green});
            base = hct_pkg::H_W'(4 * hct_pkg::ONE);
        end
        abs_diff = diff[hct_pkg::Q_W] ? hct_pkg::Q_W'(-diff) : diff[hct_pkg::Q_W-1:0];

        // Zero denominators only occur with zero numerators; divide by one then
        den_hue_next = (delta == '0) ? hct_pkg::Q_W'(1) : delta;
        den_sat_next = (mx == '0) ? hct_pkg::Q_W'(1) : mx;
        dvd_hue_next = (hct_pkg::DVD_W'(abs_diff) << hct_pkg::FRAC_BITS)
                     + hct_pkg::DVD_W'(delta >> 1);
        dvd_sat_next = (hct_pkg::DVD_W'(delta) << hct_pkg::FRAC_BITS)
                     + hct_pkg::DVD_W'(mx >> 1);

        alpha_prod = hct_pkg::MUL_W'(cap_reg.pass.alpha)
                   * hct_pkg::MUL_W'(cap_reg.record_alpha);

        side_next.pass       = cap_reg.pass;
        side_next.pass.alpha = hct_pkg::round_q(alpha_prod);
        side_next.sat_adj    = cap_reg.sat_adj;
        side_next.sat_add    = cap_reg.sat_add;
        side_next.val_adj    = cap_reg.val_adj;
        side_next.val_add    = cap_reg.val_add;
        side_next.hue_sh     = cap_reg.hue_sh;
        side_next.base       = base;
        side_next.neg        = diff[hct_pkg::Q_W];
        side_next.value      = mx;
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            side_reg    <= side_next;
            dvd_hue_reg <= dvd_hue_next;
            den_hue_reg <= den_hue_next;
            dvd_sat_reg <= dvd_sat_next;
            den_sat_reg <= den_sat_next;
        end
    end

    assign side    = side_reg;
    assign dvd_hue = dvd_hue_reg;
    assign den_hue = den_hue_reg;
    assign dvd_sat = dvd_sat_reg;
    assign den_sat = den_sat_reg;

endmodule

>>> rtl/hct_div.sv
// ============================================================================
// hct_div
// Pipelined restoring divider, one quotient bit per stage.
// ============================================================================
module hct_div (
    input  logic                              clk,
    input  logic [hct_pkg::DIV_STAGES-1:0]    en,
    input  logic [hct_pkg::DVD_W-1:0]         dvd,
    input  logic [hct_pkg::Q_W-1:0]           den,
    output logic [hct_pkg::Q_W-1:0]           quo
);

    logic [hct_pkg::DVD_W-1:0] rem_reg [hct_pkg::DIV_STAGES];
    logic [hct_pkg::Q_W-1:0]   den_reg [hct_pkg::DIV_STAGES];
    logic [hct_pkg::Q_W-1:0]   quo_reg [hct_pkg::DIV_STAGES];

    for (genvar j = 0; j < hct_pkg::DIV_STAGES; j++)
    begin : g_stage
        localparam int B = hct_pkg::DIV_STAGES - 1 - j;

        logic [hct_pkg::DVD_W-1:0] rem_in;
        logic [hct_pkg::DVD_W-1:0] sub;
        logic [hct_pkg::Q_W-1:0]   den_in;
        logic [hct_pkg::Q_W-1:0]   quo_in;
        logic [hct_pkg::Q_W-1:0]   quo_next;
        logic                      fits;

        if (j == 0)
        begin : g_first
            assign rem_in = dvd;
            assign den_in = den;
            assign quo_in = '0;
        end
        else
        begin : g_rest
            assign rem_in = rem_reg[j-1];
            assign den_in = den_reg[j-1];
            assign quo_in = quo_reg[j-1];
        end

        assign sub  = hct_pkg::DVD_W'(den_in) << B;
        assign fits = (rem_in >= sub);

        always_comb
        begin
            quo_next    = quo_in;
            quo_next[B] = fits;
        end

        always_ff @(posedge clk)
        begin
            if (en[j])
            begin
                rem_reg[j] <= fits ? (rem_in - sub) : rem_in;
                den_reg[j] <= den_in;
                quo_reg[j] <= quo_next;
            end
        end
    end

    assign quo = quo_reg[hct_pkg::DIV_STAGES-1];

endmodule

>>> rtl/hct_adjust.sv
// ============================================================================
// hct_adjust
// Hue assembly and shift, saturation and value adjust with clamping.
// ============================================================================
module hct_adjust (
    input  logic                      clk,
    input  logic [1:0]                en,
    input  hct_pkg::side_t            side,
    input  logic [hct_pkg::Q_W-1:0]   quo_hue,
    input  logic [hct_pkg::Q_W-1:0]   quo_sat,
    output hct_pkg::hsv_t             hsv
);

    typedef struct packed {
        hct_pkg::pass_t                          pass;
        logic [hct_pkg::H_W-1:0]                 hue;
        logic [hct_pkg::H_W-1:0]                 shift6;
        logic [hct_pkg::Q_W-1:0]                 sat;
        logic [hct_pkg::Q_W-1:0]                 value;
        logic signed [hct_pkg::PROD_W-1:0]       sat_prod;
        logic signed [hct_pkg::PROD_W-1:0]       val_prod;
        logic signed [hct_pkg::ADJ_W-1:0]        sat_adj;
        logic                                    sat_add;
        logic signed [hct_pkg::ADJ_W-1:0]        val_adj;
        logic                                    val_add;
    } mid_t;

    mid_t                                 mid_next, mid_reg;
    hct_pkg::hsv_t                        hsv_next, hsv_reg;
    logic signed [hct_pkg::H_W+1:0]       h_raw;
    logic [hct_pkg::H_W:0]                h_sum;
    logic signed [hct_pkg::PROD_W-1:0]    sat_sum, val_sum;

    // Stage A: sector base plus offset, shift term, adjust products
    always_comb
    begin
        if (side.neg)
            h_raw = $signed({2'b0, side.base}) - $signed({3'b0, quo_hue});
        else
            h_raw = $signed({2'b0, side.base}) + $signed({3'b0, quo_hue});
        if (h_raw < 0)
            h_raw = h_raw + (hct_pkg::H_W+2)'(hct_pkg::TURN);

        mid_next.pass     = side.pass;
        mid_next.hue      = h_raw[hct_pkg::H_W-1:0];
        // shift modulo one turn only needs its fraction bits, times six
        mid_next.shift6   = hct_pkg::H_W'(side.hue_sh) * hct_pkg::H_W'(6);
        mid_next.sat      = quo_sat;
        mid_next.value    = side.value;
        mid_next.sat_prod = $signed({1'b0, quo_sat}) * side.sat_adj;
        mid_next.val_prod = $signed({1'b0, side.value}) * side.val_adj;
        mid_next.sat_adj  = side.sat_adj;
        mid_next.sat_add  = side.sat_add;
        mid_next.val_adj  = side.val_adj;
        mid_next.val_add  = side.val_add;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
            mid_reg <= mid_next;
    end

    // Stage B: wrap hue, clamp saturation and value
    always_comb
    begin
        h_sum = (hct_pkg::H_W+1)'(mid_reg.hue) + (hct_pkg::H_W+1)'(mid_reg.shift6);
        if (h_sum >= (hct_pkg::H_W+1)'(hct_pkg::TURN))
            h_sum = h_sum - (hct_pkg::H_W+1)'(hct_pkg::TURN);

        sat_sum = $signed({{(hct_pkg::PROD_W-hct_pkg::Q_W){1'b0}}, mid_reg.sat})
                + hct_pkg::PROD_W'(mid_reg.sat_adj);
        val_sum = $signed({{(hct_pkg::PROD_W-hct_pkg::Q_W){1'b0}}, mid_reg.value})
                + hct_pkg::PROD_W'(mid_reg.val_adj);

        hsv_next.pass  = mid_reg.pass;
        hsv_next.hue   = h_sum[hct_pkg::H_W-1:0];
        hsv_next.sat   = mid_reg.sat_add ? hct_pkg::sat_unit(sat_sum)
                       : hct_pkg::sat_unit(hct_pkg::qmul_pos(mid_reg.sat_prod));
        hsv_next.value = mid_reg.val_add ? hct_pkg::sat_unit(val_sum)
                       : hct_pkg::sat_unit(hct_pkg::qmul_pos(mid_reg.val_prod));
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
            hsv_reg <= hsv_next;
    end

    assign hsv = hsv_reg;

endmodule

>>> rtl/hct_hsv2rgb.sv
// ============================================================================
// hct_hsv2rgb
// HSV back to RGB in four stages, the last of which selects the output channels.
// ============================================================================
module hct_hsv2rgb (
    input  logic                    clk,
    input  logic [3:0]              en,
    input  hct_pkg::hsv_t           hsv,
    output hct_pkg::result_t        result
);

    typedef struct packed {
        hct_pkg::pass_t                  pass;
        hct_pkg::sector_t                sector;
        logic [hct_pkg::Q_W-1:0]         sat;
        logic [hct_pkg::Q_W-1:0]         value;
        logic [hct_pkg::MUL_W-1:0]       sf;
        logic [hct_pkg::MUL_W-1:0]       sf_inv;
        logic [hct_pkg::MUL_W-1:0]       pm;
    } prod1_t;

    typedef struct packed {
        hct_pkg::pass_t                  pass;
        hct_pkg::sector_t                sector;
        logic [hct_pkg::Q_W-1:0]         sat;
        logic [hct_pkg::Q_W-1:0]         value;
        logic [hct_pkg::Q_W-1:0]         qv;
        logic [hct_pkg::Q_W-1:0]         tv;
        logic [hct_pkg::Q_W-1:0]         p;
    } fact_t;

    typedef struct packed {
        hct_pkg::pass_t                  pass;
        hct_pkg::sector_t                sector;
        logic [hct_pkg::Q_W-1:0]         sat;
        logic [hct_pkg::Q_W-1:0]         value;
        logic [hct_pkg::MUL_W-1:0]       qm;
        logic [hct_pkg::MUL_W-1:0]       tm;
        logic [hct_pkg::Q_W-1:0]         p;
    } prod2_t;

    prod1_t                      p1_next, p1_reg;
    fact_t                       fa_next, fa_reg;
    prod2_t                      p2_next, p2_reg;
    hct_pkg::result_t            res_next, res_reg;
    logic [hct_pkg::Q_W-1:0]     frac_f, q, t;

    always_comb
    begin
        frac_f         = hct_pkg::Q_W'(hsv.hue[hct_pkg::FRAC_BITS-1:0]);
        p1_next.pass   = hsv.pass;
        p1_next.sector = hct_pkg::sector_t'(hsv.hue[hct_pkg::H_W-1:hct_pkg::FRAC_BITS]);
        p1_next.sat    = hsv.sat;
        p1_next.value  = hsv.value;
        p1_next.sf     = hct_pkg::MUL_W'(hsv.sat) * hct_pkg::MUL_W'(frac_f);
        p1_next.sf_inv = hct_pkg::MUL_W'(hsv.sat) * hct_pkg::MUL_W'(hct_pkg::ONE_Q - frac_f);
        p1_next.pm     = hct_pkg::MUL_W'(hsv.value) * hct_pkg::MUL_W'(hct_pkg::ONE_Q - hsv.sat);
    end

    always_comb
    begin
        fa_next.pass   = p1_reg.pass;
        fa_next.sector = p1_reg.sector;
        fa_next.sat    = p1_reg.sat;
        fa_next.value  = p1_reg.value;
        fa_next.qv     = hct_pkg::ONE_Q - hct_pkg::round_q(p1_reg.sf);
        fa_next.tv     = hct_pkg::ONE_Q - hct_pkg::round_q(p1_reg.sf_inv);
        fa_next.p      = hct_pkg::round_q(p1_reg.pm);
    end

    always_comb
    begin
        p2_next.pass   = fa_reg.pass;
        p2_next.sector = fa_reg.sector;
        p2_next.sat    = fa_reg.sat;
        p2_next.value  = fa_reg.value;
        p2_next.qm     = hct_pkg::MUL_W'(fa_reg.value) * hct_pkg::MUL_W'(fa_reg.qv);
        p2_next.tm     = hct_pkg::MUL_W'(fa_reg.value) * hct_pkg::MUL_W'(fa_reg.tv);
        p2_next.p      = fa_reg.p;
    end

    // Pick channels by sector; disabled items pass through, gray ones take value, skipped ones are zeroed
    always_comb
    begin
        q = hct_pkg::round_q(p2_reg.qm);
        t = hct_pkg::round_q(p2_reg.tm);
        res_next.index   = p2_reg.pass.index;
        res_next.skipped = p2_reg.pass.skipped;
        res_next.alpha   = p2_reg.pass.alpha;
        res_next.red     = p2_reg.pass.red;
        res_next.green   = p2_reg.pass.green;
        res_next.blue    = p2_reg.pass.blue;
        if (p2_reg.pass.enable)
        begin
            if (p2_reg.sat == '0)
            begin
                res_next.red   = p2_reg.value;
                res_next.green = p2_reg.value;
                res_next.blue  = p2_reg.value;
            end
            else
            begin
                case (p2_reg.sector)
                    hct_pkg::SECT_RED:
                    begin
                        res_next.red = p2_reg.value; res_next.green = t; res_next.blue = p2_reg.p;
                    end
                    hct_pkg::SECT_YELLOW:
                    begin
                        res_next.red = q; res_next.green = p2_reg.value; res_next.blue = p2_reg.p;
                    end
                    hct_pkg::SECT_GREEN:
                    begin
                        res_next.red = p2_reg.p; res_next.green = p2_reg.value; res_next.blue = t;
                    end
                    hct_pkg::SECT_CYAN:
                    begin
                        res_next.red = p2_reg.p; res_next.green = q; res_next.blue = p2_reg.value;
                    end
                    hct_pkg::SECT_BLUE:
                    begin
                        res_next.red = t; res_next.green = p2_reg.p; res_next.blue = p2_reg.value;
                    end
                    default:
                    begin
                        res_next.red = p2_reg.value; res_next.green = p2_reg.p; res_next.blue = q;
                    end
                endcase
            end
        end
        if (p2_reg.pass.skipped)
        begin
            res_next.red   = '0;
            res_next.green = '0;
            res_next.blue  = '0;
            res_next.alpha = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) p1_reg  <= p1_next;
        if (en[1]) fa_reg  <= fa_next;
        if (en[2]) p2_reg  <= p2_next;
        if (en[3]) res_reg <= res_next;
    end

    assign result = res_reg;

endmodule

>>> rtl/hsv_color_tint.sv
// ============================================================================
// hsv_color_tint
// Pipeline: 21 register stages, the last being the result register.
// Throughput: one item per cycle while out_ready is high or a bubble remains;
// the 13-stage divider pipelines set depth.
// Reset (rst_n low, async): clears stage valid bits and record_count to 0.
// Per-item RGB->HSV tint->RGB in Q12, with alpha scaling and index check.
// ============================================================================
module hsv_color_tint (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // APB-style configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [hct_pkg::ADDR_W-1:0]            paddr,
    input  logic [hct_pkg::DATA_W-1:0]            pwdata,
    output logic [hct_pkg::DATA_W-1:0]            prdata,
    output logic                                  pready,
    // input channel
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [hct_pkg::IDX_W-1:0]      record_index,
    input  logic [hct_pkg::Q_W-1:0]               channel_red,
    input  logic [hct_pkg::Q_W-1:0]               channel_green,
    input  logic [hct_pkg::Q_W-1:0]               channel_blue,
    input  logic [hct_pkg::Q_W-1:0]               channel_alpha,
    input  logic                                  adjust_enable,
    input  logic signed [hct_pkg::ADJ_W-1:0]      hue_shift,
    input  logic signed [hct_pkg::ADJ_W-1:0]      sat_adjust,
    input  logic                                  sat_additive,
    input  logic signed [hct_pkg::ADJ_W-1:0]      val_adjust,
    input  logic                                  val_additive,
    input  logic [hct_pkg::Q_W-1:0]               record_alpha,
    // output channel
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [hct_pkg::OUT_IDX_W-1:0]         out_index,
    output logic                                  skipped,
    output logic [hct_pkg::Q_W-1:0]               out_red,
    output logic [hct_pkg::Q_W-1:0]               out_green,
    output logic [hct_pkg::Q_W-1:0]               out_blue,
    output logic [hct_pkg::Q_W-1:0]               out_alpha
);

    localparam int N      = hct_pkg::N_STAGES;
    localparam int DIV_LO = hct_pkg::FRONT_STAGES;
    localparam int ADJ_LO = DIV_LO + hct_pkg::DIV_STAGES;
    localparam int RGB_LO = ADJ_LO + hct_pkg::ADJ_STAGES;

    logic [hct_pkg::CNT_W-1:0]    record_count_reg;
    logic [N-1:0]                 valid_reg, valid_next;
    logic [N-1:0]                 en;
    logic [N-1:0]                 valid_prev;

    hct_pkg::side_t               side_front;
    hct_pkg::side_t               side_reg [hct_pkg::DIV_STAGES];
    logic [hct_pkg::DVD_W-1:0]    dvd_hue, dvd_sat;
    logic [hct_pkg::Q_W-1:0]      den_hue, den_sat, quo_hue, quo_sat;
    hct_pkg::hsv_t                hsv;
    hct_pkg::result_t             result;

    // ------------------------------------------------------------------
    // Configuration: write on the access phase, read back the count.
    // ------------------------------------------------------------------
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            record_count_reg <= '0;
        else if (psel && penable && pwrite
                 && (paddr[2:2] == hct_pkg::REG_RECORD_COUNT))
            record_count_reg <= pwdata[hct_pkg::CNT_W-1:0];
    end

    assign prdata = (paddr[2:2] == hct_pkg::REG_RECORD_COUNT)
                  ? hct_pkg::DATA_W'(record_count_reg) : '0;

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage advances when the output is being
    // taken or some stage at or after it holds a bubble, so bubbles get
    // squeezed out during a stall and nothing is dropped or repeated.
    // ------------------------------------------------------------------
    assign valid_prev = {valid_reg[N-2:0], in_valid};

    always_comb
    begin
        for (int k = 0; k < N; k++)
        begin
            en[k] = out_ready
                  || !(&(valid_reg | ((N'(1) << k) - N'(1))));
            valid_next[k] = en[k] ? valid_prev[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign in_ready  = en[0];
    assign out_valid = valid_reg[N-1];

    // ------------------------------------------------------------------
    // Datapath: front end, two divider lanes (hue offset and saturation)
    // with the sideband riding beside them, adjust, back conversion.
    // ------------------------------------------------------------------
    hct_front u_front (
        .clk           (clk),
        .en            (en[1:0]),
        .record_count  (record_count_reg),
        .record_index  (record_index),
        .channel_red   (channel_red),
        .channel_green (channel_green),
        .channel_blue  (channel_blue),
        .channel_alpha (channel_alpha),
        .adjust_enable (adjust_enable),
        .hue_shift     (hue_shift),
        .sat_adjust    (sat_adjust),
        .sat_additive  (sat_additive),
        .val_adjust    (val_adjust),
        .val_additive  (val_additive),
        .record_alpha  (record_alpha),
        .side          (side_front),
        .dvd_hue       (dvd_hue),
        .den_hue       (den_hue),
        .dvd_sat       (dvd_sat),
        .den_sat       (den_sat)
    );

    hct_div u_div_hue (
        .clk (clk),
        .en  (en[DIV_LO +: hct_pkg::DIV_STAGES]),
        .dvd (dvd_hue),
        .den (den_hue),
        .quo (quo_hue)
    );

    hct_div u_div_sat (
        .clk (clk),
        .en  (en[DIV_LO +: hct_pkg::DIV_STAGES]),
        .dvd (dvd_sat),
        .den (den_sat),
        .quo (quo_sat)
    );

    // Hold the sideband in step with the divider stages
    always_ff @(posedge clk)
    begin
        for (int j = 0; j < hct_pkg::DIV_STAGES; j++)
        begin
            if (en[DIV_LO + j])
                side_reg[j] <= (j == 0) ? side_front : side_reg[(j == 0) ? 0 : j - 1];
        end
    end

    hct_adjust u_adjust (
        .clk     (clk),
        .en      (en[ADJ_LO +: hct_pkg::ADJ_STAGES]),
        .side    (side_reg[hct_pkg::DIV_STAGES-1]),
        .quo_hue (quo_hue),
        .quo_sat (quo_sat),
        .hsv     (hsv)
    );

    hct_hsv2rgb u_hsv2rgb (
        .clk    (clk),
        .en     (en[RGB_LO +: hct_pkg::RGB_STAGES]),
        .hsv    (hsv),
        .result (result)
    );

    // Result register is the last stage; drive the ports straight off it
    assign out_index = result.index;
    assign skipped   = result.skipped;
    assign out_red   = result.red;
    assign out_green = result.green;
    assign out_blue  = result.blue;
    assign out_alpha = result.alpha;

`ifndef NO_ASSERTIONS
    a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && skipped |-> out_red == '0 && out_green == '0
                                 && out_blue == '0 && out_alpha == '0)
        else $error("skipped result carries nonzero color");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_red <= hct_pkg::ONE_Q && out_green <= hct_pkg::ONE_Q
                      && out_blue <= hct_pkg::ONE_Q && out_alpha <= hct_pkg::ONE_Q)
        else $error("result channel above one");

    a_ready_with_bubble: assert property (@(posedge clk) disable iff (!rst_n)
        !(&valid_reg) |-> in_ready)
        else $error("input stalled although pipeline has a bubble");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg[0])
        else $error("accepted transfer not captured in first stage");
`endif

endmodule
